/* rtl/assert_macros.svh */
// Assertion macros for the clusterer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, clk, rstn) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, clk, rstn) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("%m failed");
`endif

/* rtl/dbscan_pkg.sv */
// Types and constants for the DBSCAN point clusterer
package dbscan_pkg;
  localparam int COORD_BITS = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic CFG_RADIUS     = 1'b0;
  localparam logic CFG_MIN_POINTS = 1'b1;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [5:0] point_index;
    logic [6:0] cluster_label;
    logic [6:0] cluster_total;
    logic       overflowed;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] data;
    logic        index;
  } cfg_write_t;
endpackage

/* rtl/dbscan_dist.sv */
// Shared squared-distance unit: one axis squared per cycle, sum compared to radius squared
module dbscan_dist import dbscan_pkg::*; #(
  parameter int CoordBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [3*CoordBits-1:0] pa_i,
  input  logic [3*CoordBits-1:0] pb_i,
  input  logic [15:0]          radius_i,
  output logic                 done_o,
  output logic                 near_o
);
  localparam int DW = CoordBits + 1;
  localparam int SW = 2 * CoordBits + 2;

  logic [1:0]            axis_q, axis_d;
  logic                  busy_q, busy_d;
  logic                  done_q;
  logic [SW-1:0]         acc_q, acc_d;
  logic signed [CoordBits-1:0] ca, cb;
  logic signed [DW-1:0]  diff;
  logic [DW-1:0]         adiff;
  logic [CoordBits-1:0]  mag;
  logic [2*CoordBits-1:0] sq;
  logic [31:0]           r2;

  always_comb begin
    case (axis_q)
      2'd0:    begin ca = pa_i[CoordBits-1:0];             cb = pb_i[CoordBits-1:0]; end
      2'd1:    begin ca = pa_i[2*CoordBits-1:CoordBits];   cb = pb_i[2*CoordBits-1:CoordBits]; end
      default: begin ca = pa_i[3*CoordBits-1:2*CoordBits]; cb = pb_i[3*CoordBits-1:2*CoordBits]; end
    endcase
    diff  = DW'(ca) - DW'(cb);
    // the magnitude of a coordinate difference always fits the coordinate width
    adiff = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
    mag   = adiff[CoordBits-1:0];
    sq    = (2*CoordBits)'(mag) * (2*CoordBits)'(mag);
    r2    = 32'(radius_i) * 32'(radius_i);
  end

  always_comb begin
    busy_d = busy_q;
    axis_d = axis_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      axis_d = 2'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + SW'(sq);
      if (axis_q == 2'd2) busy_d = 1'b0;
      else axis_d = axis_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      axis_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      axis_q <= axis_d;
      done_q <= busy_q && (axis_q == 2'd2) && !start_i;
    end
  end

  always_ff @(posedge clk_i) acc_q <= acc_d;

  assign done_o = done_q;
  assign near_o = (acc_q <= SW'(r2));
endmodule

/* rtl/dbscan_point_clusterer.sv */
// DBSCAN point clusterer, top level. Loads, clears and config writes are taken
// only while the block is idle. A run visits points in load order; each
// neighbour test passes through the shared squared-distance unit in steps
// (address, start, three axis steps, verdict). Each core test sweeps all N
// points and a core point or core seed sweeps them again to label its
// neighbours. The input stalls for the whole run. Results leave through an
// output register, one point per transfer; each label is read and then
// registered for output, and the output holds while the receiver stalls.
`include "assert_macros.svh"
module dbscan_point_clusterer import dbscan_pkg::*; #(
  parameter int MaxPoints = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  cfg_write_t cfg_data_i
);
  localparam int IW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int PW = 3 * COORD_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VISIT  = 4'd1;
  localparam logic [3:0] S_CNT    = 4'd2;
  localparam logic [3:0] S_CNTW   = 4'd3;
  localparam logic [3:0] S_EXP    = 4'd4;
  localparam logic [3:0] S_EXPW   = 4'd5;
  localparam logic [3:0] S_SEED   = 4'd6;
  localparam logic [3:0] S_SEEDRD = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_EMITW  = 4'd9;
  localparam logic [3:0] S_FETCH  = 4'd10;

  logic [PW-1:0] pstore [MaxPoints];
  logic [6:0]    lstore [MaxPoints];
  logic [IW-1:0] squeue [MaxPoints];
  logic [MaxPoints-1:0] mark_q, mark_d;

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic        ovf_q, ovf_d;
  logic [15:0] radius_q;
  logic [6:0]  minpts_q;
  logic [6:0]  cid_q, cid_d;
  logic [CW-1:0] p_q, p_d;    // point being visited
  logic [IW-1:0] c_q, c_d;    // centre of current sweep
  logic [CW-1:0] j_q, j_d;    // sweep index
  logic [CW-1:0] nb_q, nb_d;  // neighbour count
  logic [7:0]    nb_next;
  logic [CW-1:0] qh_q, qh_d, ql_q, ql_d;
  logic        seedph_q, seedph_d; // sweep belongs to a seed
  logic        ov_q, ov_d;
  out_item_t   out_q, out_d;

  logic [PW-1:0] pa_q, pb_q;
  logic [IW-1:0] ra_q, ra_q_d;
  logic [6:0]    lab_rd_q;
  logic [IW-1:0] sq_rd_q;
  logic          start;
  logic          dist_done, dist_near;
  logic          dist_busy_q;

  // memory write ports
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [6:0]    lw_data;
  logic          qw_en;

  dbscan_dist #(.CoordBits(COORD_BITS)) u_dist (
    .clk_i, .rst_ni, .start_i(start), .pa_i(pa_q), .pb_i(pb_q),
    .radius_i(radius_q), .done_o(dist_done), .near_o(dist_near)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  wire [IW-1:0] jx = j_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && in_data_i.op == OP_LOAD && count_q < CW'(MaxPoints))
      pstore[count_q[IW-1:0]] <= {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
    pa_q <= pstore[c_d];
    pb_q <= pstore[ra_q];
    if (lw_en) lstore[lw_addr] <= lw_data;
    lab_rd_q <= lstore[ra_q];
    if (qw_en) squeue[ql_q[IW-1:0]] <= jx;
    sq_rd_q <= squeue[qh_q[IW-1:0]];
  end

  always_comb begin
    state_d = state_q; count_d = count_q; ovf_d = ovf_q; cid_d = cid_q;
    p_d = p_q; c_d = c_q; j_d = j_q; nb_d = nb_q; qh_d = qh_q; ql_d = ql_q;
    seedph_d = seedph_q; mark_d = mark_q; ov_d = ov_q; out_d = out_q;
    start = 1'b0; lw_en = 1'b0; lw_addr = jx; lw_data = cid_q; qw_en = 1'b0;
    ra_q_d = jx;
    nb_next = 8'(nb_q) + 8'(dist_near);
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        case (in_data_i.op)
          OP_LOAD: if (count_q < CW'(MaxPoints)) count_d = count_q + 1'b1;
                   else ovf_d = 1'b1;
          OP_CLEAR: begin count_d = '0; ovf_d = 1'b0; end
          OP_RUN: if (count_q != '0) begin
            mark_d = '1; cid_d = 7'd1; p_d = '0; state_d = S_VISIT;
          end
          default: ;
        endcase
      end
      S_VISIT: begin
        if (p_q == count_q) begin
          // every point visited
          j_d = '0; state_d = S_FETCH;
        end else if (!mark_q[p_q[IW-1:0]]) begin
          p_d = p_q + 1'b1;
        end else begin
          c_d = p_q[IW-1:0]; j_d = '0; nb_d = '0; seedph_d = 1'b0; state_d = S_CNT;
        end
      end
      S_CNT: begin
        ra_q_d = jx; state_d = S_CNTW;
      end
      S_CNTW: begin
        if (!dist_busy_q) start = 1'b1;
        if (dist_done) begin
          if (dist_near) nb_d = nb_q + 1'b1;
          if (j_q == count_q - 1'b1) begin
            j_d = '0;
            if (nb_next >= {1'b0, minpts_q}) begin
              if (!seedph_q) ql_d = '0;
              if (!seedph_q) qh_d = '0;
              state_d = S_EXP;
            end else begin
              if (!seedph_q) begin
                mark_d[c_q] = 1'b0; lw_en = 1'b1; lw_addr = c_q; lw_data = '0;
              end
              state_d = seedph_q ? S_SEED : S_VISIT;
              if (!seedph_q) p_d = p_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1; state_d = S_CNT;
          end
        end
      end
      S_EXP: begin ra_q_d = jx; state_d = S_EXPW; end
      S_EXPW: begin
        if (!dist_busy_q) start = 1'b1;
        if (dist_done) begin
          if (dist_near) begin
            if (!seedph_q) begin
              lw_en = 1'b1; mark_d[jx] = 1'b0;
              if (jx != c_q) begin qw_en = 1'b1; ql_d = ql_q + 1'b1; end
            end else if (mark_q[jx]) begin
              lw_en = 1'b1; mark_d[jx] = 1'b0; qw_en = 1'b1; ql_d = ql_q + 1'b1;
            end else if (lab_rd_q == '0) begin
              lw_en = 1'b1;
            end
          end
          if (j_q == count_q - 1'b1) state_d = S_SEED;
          else begin j_d = j_q + 1'b1; state_d = S_EXP; end
        end
      end
      S_SEED: begin
        if (qh_q == ql_q) begin
          cid_d = cid_q + 1'b1; p_d = p_q + 1'b1; state_d = S_VISIT;
        end else state_d = S_SEEDRD;
      end
      S_SEEDRD: begin
        c_d = sq_rd_q; qh_d = qh_q + 1'b1; j_d = '0; nb_d = '0; seedph_d = 1'b1;
        state_d = S_CNT;
      end
      S_FETCH: begin ra_q_d = jx; state_d = S_EMIT; end
      S_EMIT: state_d = S_EMITW;
      S_EMITW: if (!ov_q || !out_stall_i) begin
        ov_d = 1'b1;
        out_d.point_index   = 6'(j_q);
        out_d.cluster_label = lab_rd_q;
        out_d.cluster_total = cid_q - 1'b1;
        out_d.overflowed    = ovf_q;
        out_d.last          = (j_q == count_q - 1'b1);
        if (j_q == count_q - 1'b1) state_d = S_IDLE;
        else begin j_d = j_q + 1'b1; state_d = S_FETCH; end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; ovf_q <= 1'b0; cid_q <= '0;
      p_q <= '0; c_q <= '0; j_q <= '0; nb_q <= '0; qh_q <= '0; ql_q <= '0;
      seedph_q <= 1'b0; mark_q <= '0; ov_q <= 1'b0; ra_q <= '0;
      radius_q <= 16'd256; minpts_q <= 7'd3; dist_busy_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovf_q <= ovf_d; cid_q <= cid_d;
      p_q <= p_d; c_q <= c_d; j_q <= j_d; nb_q <= nb_d; qh_q <= qh_d; ql_q <= ql_d;
      seedph_q <= seedph_d; mark_q <= mark_d; ov_q <= ov_d; ra_q <= ra_q_d;
      if (start) dist_busy_q <= 1'b1;
      else if (dist_done) dist_busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_data_i.index == CFG_RADIUS) radius_q <= cfg_data_i.data;
        else minpts_q <= cfg_data_i.data[6:0];
      end
    end
  end

  always_ff @(posedge clk_i) out_q <= out_d;

  `ASSERT_IMPLIES(a_stall_busy, state_q != S_IDLE, in_stall_o, clk_i, rst_ni)
  `ASSERT_IMPLIES(a_queue_order, state_q != S_IDLE, qh_q <= ql_q, clk_i, rst_ni)
  `ASSERT_IMPLIES(a_cnt_bound, 1'b1, count_q <= CW'(MaxPoints), clk_i, rst_ni)
endmodule

/* verif/tb.sv */
// Self-checking testbench for the DBSCAN point clusterer
`timescale 1ns / 1ps
module tb;
  import dbscan_pkg::*;

  localparam int NPTS = 64;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  class label_scoreboard;
    logic signed [15:0] px[NPTS], py[NPTS], pz[NPTS];
    int unsigned count;
    bit ovf;
    int unsigned radius;
    int unsigned min_pts;
    out_item_t pending[$];
    int errors;
    int runs;
    int results_seen;

    function void reset_state();
      count = 0; ovf = 0; radius = 256; min_pts = 3;
      pending.delete(); errors = 0; runs = 0; results_seen = 0;
    endfunction

    function bit near(int a, int b);
      longint dx, dy, dz;
      longint unsigned sq, r2;
      dx = longint'(px[a]) - longint'(px[b]);
      dy = longint'(py[a]) - longint'(py[b]);
      dz = longint'(pz[a]) - longint'(pz[b]);
      sq = dx * dx + dy * dy + dz * dz;
      r2 = longint'(radius) * longint'(radius);
      return sq <= r2;
    endfunction

    function bit core(int a);
      int cnt;
      cnt = 0;
      for (int j = 0; j < count; j++) if (near(a, j)) cnt++;
      return cnt >= min_pts;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_RADIUS) radius = 32'(val);
      else min_pts = 32'(val[6:0]);
    endfunction

    function void cluster_points();
      bit unmarked[NPTS];
      int lbl[NPTS];
      int seeds[NPTS];
      int qlen;
      int cid, q;
      out_item_t r;
      cid = 1;
      for (int p = 0; p < count; p++) begin
        unmarked[p] = 1; lbl[p] = 0;
      end
      for (int p = 0; p < count; p++) begin
        if (!unmarked[p]) continue;
        if (!core(p)) begin
          unmarked[p] = 0; lbl[p] = 0; continue;
        end
        qlen = 0;
        // relabel every neighbour of the initial core point, whatever it held
        for (int j = 0; j < count; j++) begin
          if (!near(p, j)) continue;
          lbl[j] = cid; unmarked[j] = 0;
          if (j != p && qlen < NPTS) begin seeds[qlen] = j; qlen++; end
        end
        for (int h = 0; h < qlen && h < NPTS; h++) begin
          q = seeds[h];
          if (!core(q)) continue;
          for (int j = 0; j < count; j++) begin
            if (!near(q, j)) continue;
            if (unmarked[j]) begin
              unmarked[j] = 0; lbl[j] = cid;
              if (qlen < NPTS) begin seeds[qlen] = j; qlen++; end
            end else if (lbl[j] == 0) lbl[j] = cid;
          end
        end
        cid++;
      end
      for (int i = 0; i < count; i++) begin
        r.point_index = i[5:0];
        r.cluster_label = lbl[i][6:0];
        r.cluster_total = 7'(cid - 1);
        r.overflowed = ovf;
        r.last = (i + 1 == count);
        pending = {pending, r};
      end
    endfunction

    function void note_input(in_item_t it);
      case (it.op)
        OP_LOAD: begin
          if (count < NPTS) begin
            px[count] = it.pos_x; py[count] = it.pos_y; pz[count] = it.pos_z;
            count++;
          end else ovf = 1;
        end
        OP_CLEAR: begin
          count = 0; ovf = 0;
        end
        OP_RUN: begin
          runs++;
          cluster_points();
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result index %0d", got.point_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.point_index !== want.point_index) begin
        $error("point_index expected %0d got %0d", want.point_index, got.point_index);
        errors++;
      end
      if (got.cluster_label !== want.cluster_label) begin
        $error("cluster_label expected %0d got %0d", want.cluster_label, got.cluster_label);
        errors++;
      end
      if (got.cluster_total !== want.cluster_total) begin
        $error("cluster_total expected %0d got %0d", want.cluster_total, got.cluster_total);
        errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed expected %0d got %0d", want.overflowed, got.overflowed);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_item_t out_data_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  cfg_write_t cfg_data_i = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  label_scoreboard sb;

  always #1 clk_i = ~clk_i;

  dbscan_point_clusterer DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // sample results and count cycles
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays up after a transfer until the next item or an idle cycle replaces it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    // let a run with no results finish before touching registers
    repeat (20000) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_data_i <= '{data: val, index: idx};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic load_pt(logic signed [15:0] x, y, z);
    in_item_t it;
    it.op = OP_LOAD; it.pos_x = x; it.pos_y = y; it.pos_z = z;
    send_item(it);
  endtask

  task automatic send_op(logic [1:0] op);
    in_item_t it;
    it.op = op;
    it.pos_x = 16'($urandom); it.pos_y = 16'($urandom); it.pos_z = 16'($urandom);
    send_item(it);
  endtask

  // a batch: clear, blobs of nearby points plus strays, at times an unused op, run
  task automatic random_batch(int npts);
    logic signed [15:0] cx, cy, cz;
    int spread;
    send_op(OP_CLEAR);
    cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
    spread = $urandom_range(1, 2) * int'(sb.radius) + 1;
    for (int i = 0; i < npts; i++) begin
      if ($urandom_range(3) == 0) begin
        cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
      end
      if ($urandom_range(9) == 0)
        load_pt(16'($urandom), 16'($urandom), 16'($urandom));
      else
        load_pt(cx + 16'($urandom_range(spread)), cy - 16'($urandom_range(spread)),
                cz + 16'($urandom_range(spread)));
    end
    if ($urandom_range(9) == 0) send_op(OP_UNUSED);
    send_op(OP_RUN);
  endtask

  initial begin
    int phase_idle[4] = '{0, 63, 0, 30};
    int phase_stall[4] = '{0, 0, 63, 30};
    sb = new();
    sb.reset_state();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty run, extremes, unused op, overflow, zero min_points
    send_op(OP_RUN);
    load_pt(16'sh7fff, 16'sh7fff, 16'sh7fff);
    load_pt(-16'sh8000, -16'sh8000, -16'sh8000);
    load_pt(16'sh7fff, 16'sh7f00, 16'sh7fff);
    load_pt(16'sh7f80, 16'sh7fff, 16'sh7fff);
    load_pt(16'sd0, 16'sd0, 16'sd0);
    send_op(OP_UNUSED);
    send_op(OP_RUN);
    send_op(OP_RUN);
    drain();
    write_cfg(CFG_RADIUS, 16'hffff);
    write_cfg(CFG_MIN_POINTS, 16'd0);
    send_op(OP_RUN);
    drain();
    write_cfg(CFG_RADIUS, 16'd0);
    write_cfg(CFG_MIN_POINTS, 16'd1);
    send_op(OP_RUN);
    drain();
    write_cfg(CFG_RADIUS, 16'd256);
    write_cfg(CFG_MIN_POINTS, 16'd64);
    send_op(OP_CLEAR);
    for (int i = 0; i < 66; i++) load_pt(16'(i), 16'(-i), 16'sd0);
    send_op(OP_RUN);
    drain();
    write_cfg(CFG_MIN_POINTS, 16'd3);
    send_op(OP_CLEAR);
    send_op(OP_RUN);
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int b = 0; b < 2; b++) begin
        drain();
        write_cfg(CFG_RADIUS, 16'($urandom_range(1, 3000)));
        write_cfg(CFG_MIN_POINTS, 16'($urandom_range(1, 5)));
        random_batch($urandom_range(3, 6));
      end
    end
    // hold until every result has come, then one more batch
    drain();
    random_batch(8);

    drain();
    $display("covered %0d clustering runs and %0d label results", sb.runs, sb.results_seen);
    $display("over radius and min_points settings from extreme to typical, with stalls");
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
